FILE: hdl/lud_pkg.sv
`timescale 1ns / 1ps
package lud_pkg;

	localparam int unsigned ITERATIONS = 50;
	localparam int unsigned ITER_W = 8;

	typedef struct packed {
		logic signed [31:0] pixel_u;
		logic signed [31:0] pixel_v;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] norm_x;
		logic signed [31:0] norm_y;
		logic signed [31:0] jac_xu;
		logic signed [31:0] jac_xv;
		logic signed [31:0] jac_yu;
		logic signed [31:0] jac_yv;
		logic              degenerate;
	} result_t;

	typedef enum logic [2:0] {
		REG_FOCAL_X   = 3'd0,
		REG_FOCAL_Y   = 3'd1,
		REG_CENTER_X  = 3'd2,
		REG_CENTER_Y  = 3'd3,
		REG_RADIAL_K1 = 3'd4,
		REG_RADIAL_K2 = 3'd5,
		REG_RADIAL_K3 = 3'd6,
		REG_TANGENT   = 3'd7
	} reg_index_t;

	// Sign-extend a Q4.28 word to the 40-bit accumulator width.
	function automatic logic signed [39:0] sx(input logic signed [31:0] v);
		sx = {{8{v[31]}}, v};
	endfunction

	// Saturate a 40-bit sum to 32 bits.
	function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
		if (v[39:31] == 9'h000 || v[39:31] == 9'h1ff) begin
			sat40 = v[31:0];
		end else if (v[39]) begin
			sat40 = 32'sh8000_0000;
		end else begin
			sat40 = 32'sh7fff_ffff;
		end
	endfunction

	function automatic logic oor40(input logic signed [39:0] v);
		oor40 = !(v[39:31] == 9'h000 || v[39:31] == 9'h1ff);
	endfunction

	// v * 2^28 as a 64-bit numerator.
	function automatic logic signed [63:0] q28(input logic signed [31:0] v);
		q28 = {{4{v[31]}}, v, 28'd0};
	endfunction

endpackage

FILE: hdl/lud_sample_if.sv
`timescale 1ns / 1ps
interface lud_sample_if;
	logic              valid;
	logic              ready;
	lud_pkg::sample_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/lud_result_if.sv
`timescale 1ns / 1ps
interface lud_result_if;
	logic              valid;
	logic              ready;
	lud_pkg::result_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/lud_mul.sv
`timescale 1ns / 1ps
module lud_mul (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [35:0] prod_raw,
	output logic signed [31:0] prod_sat
);
	logic signed [63:0] p_s1;
	logic        [63:0] mag;
	logic        [34:0] rq;

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

	// Round to nearest with ties away from zero, on the magnitude.
	always_comb begin
		mag = p_s1[63] ? (64'd0 - p_s1) : p_s1;
		rq = 35'((mag + 64'd134217728) >> 28);
		prod_raw = p_s1[63] ? (36'sd0 - {1'b0, rq}) : {1'b0, rq};
		prod_sat = lud_pkg::sat40({{4{prod_raw[35]}}, prod_raw});
	end
endmodule

FILE: hdl/lud_div.sv
`timescale 1ns / 1ps
module lud_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic signed [33:0] den,
	output logic               done,
	output logic signed [31:0] quot
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [32:0] rem_q;
	logic [31:0] lo_q;
	logic [31:0] quo_q;
	logic [32:0] md_q;
	logic        neg_q;
	logic        ovf_q;

	logic [63:0] mn;
	logic [32:0] md;
	logic [63:0] adj;
	logic [33:0] rem2;
	logic        ge;

	always_comb begin
		mn = num[63] ? (64'd0 - num) : num;
		md = den[33] ? 33'(34'd0 - den) : den[32:0];
		adj = mn + {32'd0, md[32:1]};
		rem2 = {rem_q, lo_q[31]};
		ge = rem2 >= {1'b0, md_q};
	end

	// One quotient bit per cycle after a one-compare overflow check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			md_q <= md;
			neg_q <= num[63] ^ den[33];
			ovf_q <= {1'b0, adj[63:32]} >= md;
			rem_q <= {1'b0, adj[63:32]};
			lo_q <= adj[31:0];
		end else if (busy_q) begin
			rem_q <= ge ? 33'(rem2 - {1'b0, md_q}) : rem2[32:0];
			lo_q <= {lo_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], ge};
		end
	end

	always_comb begin
		if (ovf_q) begin
			quot = neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else if (!neg_q) begin
			quot = quo_q[31] ? 32'sh7fff_ffff : quo_q;
		end else begin
			quot = (quo_q > 32'h8000_0000) ? 32'sh8000_0000 : (32'd0 - quo_q);
		end
	end

	assign done = done_q;
endmodule

FILE: hdl/lens_undistort_deproject.sv
`timescale 1ns / 1ps
// Inverse Brown-Conrady lens model on a fixed-point shared datapath.
// An item on the sample channel carries a distorted pixel (Q16.16); the block
// answers with one item on the result channel: the undistorted normalized
// point (Q4.28), the 2x2 pixel-to-normalized Jacobian (Q2.30) and a
// degenerate flag. Intrinsics and distortion coefficients are written through
// the cfg_we/cfg_index/cfg_data port; the user must do so only while no item
// is in flight, as the block does not enforce it. One item is worked at a
// time: sample.ready is high only while idle. An item runs from accept to
// result.valid through 109 divisions on the shared radix-2 divider and steps
// on the shared 32x32 multiplier in each refinement pass and for the final
// point and Jacobian. A pass with a zero factor skips its two divisions, and
// a zero determinant skips the seven closing ones. A new item is taken only
// once the result is taken and the block is idle again.
// With a zero focal length the result is valid the cycle after accept.
// The result is held in an output register until result.ready is seen; a
// stalled receiver holds the block idle-but-busy and no new item is taken.
// Reset returns the sequencer to idle, drops result.valid and loads the
// register reset values (unit focal lengths, everything else zero).
module lens_undistort_deproject (
	input  logic                clk,
	input  logic                arst_n,
	lud_sample_if.sink          sample,
	lud_result_if.source        result,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [47:0]         cfg_data
);
	typedef enum logic [5:0] {
		ST_IDLE, ST_NX, ST_NY,
		IT_XX, IT_YY, IT_XY, IT_R2, IT_R4, IT_R6, IT_K1, IT_K2, IT_K3, IT_L,
		IT_DX1, IT_DX2, IT_DY1, IT_DY2, IT_DIVX, IT_DIVY,
		F_F1, F_F2, F_A1, F_A2, F_A3, F_A4, F_B2, F_B3, F_B4,
		F_D2, F_D3, F_D4, F_DT1, F_DT2, F_DT3,
		F_I00, F_I01, F_I11, F_J0, F_J1, F_J2, F_J3, ST_OUT
	} state_t;

	state_t state_q;

	logic [31:0] fx_q, fy_q, cx_q, cy_q;
	logic [23:0] k1_q, k2_q, k3_q;
	logic [47:0] tan_q;

	logic signed [31:0] x_q, y_q, x2_q, y2_q, xx_q, yy_q, xy_q, r2_q, r4_q, r6_q;
	logic signed [31:0] l_q, dx_q, dy_q, f_q, a_q, b_q, d_q, det_q;
	logic signed [31:0] i00_q, i01_q, i11_q;
	logic signed [39:0] acc_q;
	logic signed [33:0] dv_q;
	logic [lud_pkg::ITER_W-1:0] iter_q;
	logic fin_q, flag_q;
	lud_pkg::result_t res_q;

	logic signed [31:0] k1, k2, k3, p1, p2;
	logic signed [31:0] ma, mb, m, mraw32;
	logic signed [35:0] mraw;
	logic signed [39:0] m40, lraw, dtraw;
	logic signed [31:0] detc;
	logic               div_start, div_done;
	logic signed [63:0] div_num;
	logic signed [33:0] div_den;
	logic signed [31:0] q;
	logic signed [33:0] du, dv;
	logic signed [39:0] nb;
	logic               accept, fzero, last_iter;

	assign k1 = {k1_q, 8'd0};
	assign k2 = {k2_q, 8'd0};
	assign k3 = {k3_q, 8'd0};
	assign p1 = {tan_q[23:0], 8'd0};
	assign p2 = {tan_q[47:24], 8'd0};

	assign sample.ready = (state_q == ST_IDLE);
	assign accept = sample.valid && sample.ready;
	assign fzero = (fx_q == 32'd0) || (fy_q == 32'd0);
	assign result.valid = (state_q == ST_OUT);
	assign result.data = res_q;
	assign last_iter = (iter_q == lud_pkg::ITER_W'(lud_pkg::ITERATIONS - 1));

	lud_mul u_mul (.clk(clk), .a(ma), .b(mb), .prod_raw(mraw), .prod_sat(m));

	lud_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quot(q)
	);

	assign m40 = lud_pkg::sx(m);
	assign mraw32 = m;
	assign lraw = acc_q + m40 + 40'sd268435456;
	assign dtraw = acc_q - {{4{mraw[35]}}, mraw};
	assign detc = lud_pkg::sat40(dtraw);
	assign du = {{2{sample.data.pixel_u[31]}}, sample.data.pixel_u} - {2'b00, cx_q};
	assign dv = {{2{sample.data.pixel_v[31]}}, sample.data.pixel_v} - {2'b00, cy_q};
	assign nb = 40'sd0 - lud_pkg::sx(b_q);

	// Operand select for the shared multiplier; its result appears next state.
	always_comb begin
		ma = 32'sd0;
		mb = 32'sd0;
		case (state_q)
			IT_XX:  begin ma = x_q;  mb = x_q;  end
			IT_YY:  begin ma = y_q;  mb = y_q;  end
			IT_XY:  begin ma = x_q;  mb = y_q;  end
			IT_R4:  begin ma = r2_q; mb = r2_q; end
			IT_R6:  begin ma = mraw32; mb = r2_q; end
			IT_K1:  begin ma = k1;   mb = r2_q; end
			IT_K2:  begin ma = k2;   mb = r4_q; end
			IT_K3:  begin ma = k3;   mb = r6_q; end
			IT_L: begin
				ma = fin_q ? k2 : p1;
				mb = fin_q ? r2_q : xy_q;
			end
			IT_DX1: begin
				ma = p2;
				mb = lud_pkg::sat40(lud_pkg::sx(r2_q) + (lud_pkg::sx(xx_q) <<< 1));
			end
			IT_DX2: begin ma = p2; mb = xy_q; end
			IT_DY1: begin
				ma = p1;
				mb = lud_pkg::sat40(lud_pkg::sx(r2_q) + (lud_pkg::sx(yy_q) <<< 1));
			end
			F_F1:   begin ma = k3;  mb = r4_q; end
			F_A1:   begin ma = f_q; mb = xx_q; end
			F_A2:   begin ma = p1;  mb = y_q;  end
			F_A3:   begin ma = p2;  mb = x_q;  end
			F_A4:   begin ma = f_q; mb = xy_q; end
			F_B2:   begin ma = p1;  mb = x_q;  end
			F_B3:   begin ma = p2;  mb = y_q;  end
			F_B4:   begin ma = f_q; mb = yy_q; end
			F_D2:   begin ma = p2;  mb = x_q;  end
			F_D3:   begin ma = p1;  mb = y_q;  end
			F_DT1:  begin ma = a_q; mb = d_q;  end
			F_DT2:  begin ma = b_q; mb = b_q;  end
			default: begin ma = 32'sd0; mb = 32'sd0; end
		endcase
	end

	// Divider launch: most launches chain on the previous division finishing.
	always_comb begin
		div_start = 1'b0;
		div_num = 64'sd0;
		div_den = 34'sd0;
		case (state_q)
			ST_IDLE: begin
				div_start = accept && !fzero;
				div_num = {{2{du[33]}}, du, 28'd0};
				div_den = {2'b00, fx_q};
			end
			ST_NX: begin
				div_start = div_done;
				div_num = {{2{dv_q[33]}}, dv_q, 28'd0};
				div_den = {2'b00, fy_q};
			end
			IT_DY2: begin
				div_start = (l_q != 32'sd0);
				div_num = lud_pkg::q28(lud_pkg::sat40(lud_pkg::sx(x2_q) - lud_pkg::sx(dx_q)));
				div_den = {{2{l_q[31]}}, l_q};
			end
			IT_DIVX: begin
				div_start = div_done;
				div_num = lud_pkg::q28(lud_pkg::sat40(lud_pkg::sx(y2_q) - lud_pkg::sx(dy_q)));
				div_den = {{2{l_q[31]}}, l_q};
			end
			F_DT3: begin
				div_start = (detc != 32'sd0);
				div_num = lud_pkg::q28(d_q);
				div_den = {{2{detc[31]}}, detc};
			end
			F_I00: begin
				div_start = div_done;
				div_num = {{2{nb[33]}}, nb[33:0], 28'd0};
				div_den = {{2{det_q[31]}}, det_q};
			end
			F_I01: begin
				div_start = div_done;
				div_num = lud_pkg::q28(a_q);
				div_den = {{2{det_q[31]}}, det_q};
			end
			F_I11: begin
				div_start = div_done;
				div_num = {{14{i00_q[31]}}, i00_q, 18'd0};
				div_den = {2'b00, fx_q};
			end
			F_J0: begin
				div_start = div_done;
				div_num = {{14{i01_q[31]}}, i01_q, 18'd0};
				div_den = {2'b00, fy_q};
			end
			F_J1: begin
				div_start = div_done;
				div_num = {{14{i01_q[31]}}, i01_q, 18'd0};
				div_den = {2'b00, fx_q};
			end
			F_J2: begin
				div_start = div_done;
				div_num = {{14{i11_q[31]}}, i11_q, 18'd0};
				div_den = {2'b00, fy_q};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_q <= 32'd65536;
			fy_q <= 32'd65536;
			cx_q <= 32'd0;
			cy_q <= 32'd0;
			k1_q <= 24'd0;
			k2_q <= 24'd0;
			k3_q <= 24'd0;
			tan_q <= 48'd0;
		end else if (cfg_we) begin
			unique case (lud_pkg::reg_index_t'(cfg_index))
				lud_pkg::REG_FOCAL_X:   fx_q <= cfg_data[31:0];
				lud_pkg::REG_FOCAL_Y:   fy_q <= cfg_data[31:0];
				lud_pkg::REG_CENTER_X:  cx_q <= cfg_data[31:0];
				lud_pkg::REG_CENTER_Y:  cy_q <= cfg_data[31:0];
				lud_pkg::REG_RADIAL_K1: k1_q <= cfg_data[23:0];
				lud_pkg::REG_RADIAL_K2: k2_q <= cfg_data[23:0];
				lud_pkg::REG_RADIAL_K3: k3_q <= cfg_data[23:0];
				lud_pkg::REG_TANGENT:   tan_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q <= '0;
			fin_q <= 1'b0;
			flag_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						flag_q <= 1'b0;
						// The row offset is kept, since the sender may move on.
						dv_q <= dv;
						if (fzero) begin
							res_q <= '{degenerate: 1'b1, default: '0};
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_NX;
						end
					end
				end
				ST_NX: begin
					if (div_done) begin
						x2_q <= q;
						x_q <= q;
						state_q <= ST_NY;
					end
				end
				ST_NY: begin
					if (div_done) begin
						y2_q <= q;
						y_q <= q;
						iter_q <= '0;
						fin_q <= 1'b0;
						state_q <= IT_XX;
					end
				end
				IT_XX: state_q <= IT_YY;
				IT_YY: begin
					xx_q <= m;
					state_q <= IT_XY;
				end
				IT_XY: begin
					yy_q <= m;
					state_q <= IT_R2;
				end
				IT_R2: begin
					xy_q <= m;
					r2_q <= lud_pkg::sat40(lud_pkg::sx(xx_q) + lud_pkg::sx(yy_q));
					state_q <= IT_R4;
				end
				IT_R4: state_q <= IT_R6;
				IT_R6: begin
					r4_q <= m;
					state_q <= IT_K1;
				end
				IT_K1: begin
					r6_q <= m;
					state_q <= IT_K2;
				end
				IT_K2: begin
					acc_q <= m40;
					state_q <= IT_K3;
				end
				IT_K3: begin
					acc_q <= acc_q + m40;
					state_q <= IT_L;
				end
				IT_L: begin
					l_q <= lud_pkg::sat40(lraw);
					if (lraw == 40'sd0 || lud_pkg::oor40(lraw)) begin
						flag_q <= 1'b1;
					end
					state_q <= fin_q ? F_F1 : IT_DX1;
				end
				IT_DX1: begin
					acc_q <= m40 <<< 1;
					state_q <= IT_DX2;
				end
				IT_DX2: begin
					dx_q <= lud_pkg::sat40(acc_q + m40);
					state_q <= IT_DY1;
				end
				IT_DY1: begin
					acc_q <= m40 <<< 1;
					state_q <= IT_DY2;
				end
				IT_DY2: begin
					dy_q <= lud_pkg::sat40(acc_q + m40);
					// A pass with a zero factor keeps the point as it is.
					if (l_q != 32'sd0) begin
						state_q <= IT_DIVX;
					end else begin
						iter_q <= iter_q + 1'b1;
						fin_q <= last_iter;
						state_q <= IT_XX;
					end
				end
				IT_DIVX: begin
					if (div_done) begin
						x_q <= q;
						state_q <= IT_DIVY;
					end
				end
				IT_DIVY: begin
					if (div_done) begin
						y_q <= q;
						iter_q <= iter_q + 1'b1;
						fin_q <= last_iter;
						state_q <= IT_XX;
					end
				end
				F_F1: begin
					acc_q <= lud_pkg::sx(k1) + (m40 <<< 1);
					state_q <= F_F2;
				end
				F_F2: begin
					f_q <= lud_pkg::sat40(acc_q + (m40 <<< 1) + m40);
					state_q <= F_A1;
				end
				F_A1: state_q <= F_A2;
				F_A2: begin
					acc_q <= lud_pkg::sx(l_q) + (m40 <<< 1);
					state_q <= F_A3;
				end
				F_A3: begin
					acc_q <= acc_q + (m40 <<< 1);
					state_q <= F_A4;
				end
				F_A4: begin
					a_q <= lud_pkg::sat40(acc_q + (m40 <<< 2) + (m40 <<< 1));
					state_q <= F_B2;
				end
				F_B2: begin
					acc_q <= m40 <<< 1;
					state_q <= F_B3;
				end
				F_B3: begin
					acc_q <= acc_q + (m40 <<< 1);
					state_q <= F_B4;
				end
				F_B4: begin
					b_q <= lud_pkg::sat40(acc_q + (m40 <<< 1));
					state_q <= F_D2;
				end
				F_D2: begin
					acc_q <= lud_pkg::sx(l_q) + (m40 <<< 1);
					state_q <= F_D3;
				end
				F_D3: begin
					acc_q <= acc_q + (m40 <<< 1);
					state_q <= F_D4;
				end
				F_D4: begin
					d_q <= lud_pkg::sat40(acc_q + (m40 <<< 2) + (m40 <<< 1));
					state_q <= F_DT1;
				end
				F_DT1: state_q <= F_DT2;
				F_DT2: begin
					acc_q <= {{4{mraw[35]}}, mraw};
					state_q <= F_DT3;
				end
				F_DT3: begin
					det_q <= detc;
					res_q.norm_x <= x_q;
					res_q.norm_y <= y_q;
					if (dtraw == 40'sd0 || lud_pkg::oor40(dtraw)) begin
						flag_q <= 1'b1;
					end
					if (detc == 32'sd0) begin
						res_q.jac_xu <= 32'sd0;
						res_q.jac_xv <= 32'sd0;
						res_q.jac_yu <= 32'sd0;
						res_q.jac_yv <= 32'sd0;
						state_q <= F_J3;
					end else begin
						state_q <= F_I00;
					end
				end
				F_I00: begin
					if (div_done) begin
						i00_q <= q;
						state_q <= F_I01;
					end
				end
				F_I01: begin
					if (div_done) begin
						i01_q <= q;
						state_q <= F_I11;
					end
				end
				F_I11: begin
					if (div_done) begin
						i11_q <= q;
						state_q <= F_J0;
					end
				end
				F_J0: begin
					if (div_done) begin
						res_q.jac_xu <= q;
						state_q <= F_J1;
					end
				end
				F_J1: begin
					if (div_done) begin
						res_q.jac_xv <= q;
						state_q <= F_J2;
					end
				end
				F_J2: begin
					if (div_done) begin
						res_q.jac_yu <= q;
						state_q <= F_J3;
					end
				end
				F_J3: begin
					// Entered either with the last division still running or with no divisions.
					if (div_done) begin
						res_q.jac_yv <= q;
					end
					if (div_done || det_q == 32'sd0) begin
						res_q.degenerate <= flag_q;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (result.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
